// ===== hdl/ofsc_pkg.sv =====
// Shared constants, codes and types for the oriented face set.
`timescale 1ns / 1ps
package ofsc_pkg;

  localparam int MAX_FACES  = 64;
  localparam int NODE_BITS  = 24;
  localparam int SLOT_W     = $clog2(MAX_FACES);
  localparam int CNT_W      = $clog2(MAX_FACES + 1);
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (MAX_FACES + GROUP - 1) / GROUP;
  localparam int GIDX_W     = $clog2(GROUP);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_CANCELLED = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND_SAME = 3'd4;
  localparam logic [2:0] ST_FOUND_REV = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic cmp;
    logic clr_all;
    logic wr;
    logic kill;
  } cell_ctl_t;

endpackage

// ===== hdl/ofsc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ofsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ofsc_cell.sv =====
// One face slot: stored triangle, valid bit, match flags and priority link.
`timescale 1ns / 1ps
module ofsc_cell import ofsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [NODE_BITS-1:0] key_a,
  input  logic [NODE_BITS-1:0] key_b,
  input  logic [NODE_BITS-1:0] key_c,
  input  logic                 taken_in,
  output logic                 taken_out,
  output logic                 first_same,
  output logic                 first_rev
);

  logic [NODE_BITS-1:0] f0, f1, f2;
  logic                 valid;
  logic                 hit_same;
  logic                 hit_rev;
  logic                 same, rev;

  assign same = (key_a == f0 && key_b == f1 && key_c == f2) ||
                (key_b == f0 && key_c == f1 && key_a == f2) ||
                (key_c == f0 && key_a == f1 && key_b == f2);
  assign rev  = (key_c == f0 && key_b == f1 && key_a == f2) ||
                (key_b == f0 && key_a == f1 && key_c == f2) ||
                (key_a == f0 && key_c == f1 && key_b == f2);

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      f0 <= key_a;
      f1 <= key_b;
      f2 <= key_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all || ctl.kill) begin
      valid <= 1'b0;
    end else if (ctl.wr) begin
      valid <= 1'b1;
    end
  end

  // same orientation wins over reversed within one slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_same <= 1'b0;
      hit_rev  <= 1'b0;
    end else if (ctl.cmp) begin
      hit_same <= valid & same;
      hit_rev  <= valid & rev & ~same;
    end
  end

  assign taken_out  = taken_in | hit_same | hit_rev;
  assign first_same = hit_same & ~taken_in;
  assign first_rev  = hit_rev & ~taken_in;

endmodule

// ===== hdl/oriented_face_set_cancel_top.sv =====
// Top level: chain of face cells, group priority, free-slot stack and control.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | func, face_node_a, face_node_b, face_node_c
//  result   | done (one cycle)   | status, slot_index, face_count
//
// Each command runs through compare in every cell, priority inside groups of
// 8 cells, then group pick plus table update; busy blocks a new command until
// the update is done. done is registered from the update. Reset needs no sweep:
// free-slot stack entries that were never pushed read back through a low-water
// mark. The receiver cannot stall.
`timescale 1ns / 1ps
module oriented_face_set_cancel_top import ofsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [23:0] face_node_a,
  input  logic [23:0] face_node_b,
  input  logic [23:0] face_node_c,
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  slot_index,
  output logic [6:0]  face_count
);

  state_t state, state_next;

  logic [1:0]           op;
  logic [NODE_BITS-1:0] key_a, key_b, key_c;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] low_f, low_f_next;
  logic [CNT_W-1:0] f_count;

  logic             in_go;
  logic             cmp_en;
  logic             upd_en;

  logic [MAX_FACES-1:0] taken;
  logic [MAX_FACES-1:0] cell_first_same;
  logic [MAX_FACES-1:0] cell_first_rev;
  logic [NUM_GROUPS*GROUP-1:0] pad_same, pad_rev;

  logic              grp_hit      [NUM_GROUPS];
  logic              grp_same     [NUM_GROUPS];
  logic [GIDX_W-1:0] grp_idx      [NUM_GROUPS];
  logic              grp_hit_next [NUM_GROUPS];
  logic              grp_same_next[NUM_GROUPS];
  logic [GIDX_W-1:0] grp_idx_next [NUM_GROUPS];

  logic              sel_hit, sel_same;
  logic [SLOT_W-1:0] sel_slot;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;
  logic [SLOT_W-1:0] pop_slot;

  logic              do_wr, do_kill, do_clr;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;

  assign in_go = start & ~busy;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_go) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_UPD;
      S_UPD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    cmp_en = 1'b0;
    upd_en = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_CMP:   cmp_en = 1'b1;
      S_GRP:   ;
      S_UPD:   upd_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      op    <= func;
      key_a <= NODE_BITS'(face_node_a);
      key_b <= NODE_BITS'(face_node_b);
      key_c <= NODE_BITS'(face_node_c);
    end
  end

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      t_in;

    if (i % GROUP == 0) begin : g_head
      assign t_in = 1'b0;
    end else begin : g_link
      assign t_in = taken[i-1];
    end

    assign ctl.cmp     = cmp_en;
    assign ctl.clr_all = do_clr;
    assign ctl.wr      = do_wr & (pop_slot == SLOT_W'(i));
    assign ctl.kill    = do_kill & (sel_slot == SLOT_W'(i));

    ofsc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key_a      (key_a),
      .key_b      (key_b),
      .key_c      (key_c),
      .taken_in   (t_in),
      .taken_out  (taken[i]),
      .first_same (cell_first_same[i]),
      .first_rev  (cell_first_rev[i])
    );
  end

  for (genvar i = 0; i < NUM_GROUPS * GROUP; i++) begin : g_pad
    if (i < MAX_FACES) begin : g_real
      assign pad_same[i] = cell_first_same[i];
      assign pad_rev[i]  = cell_first_rev[i];
    end else begin : g_none
      assign pad_same[i] = 1'b0;
      assign pad_rev[i]  = 1'b0;
    end
  end

  // ---------------------------------------------------------------- group stage
  // at most one cell per group carries a first flag
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_next[g]  = 1'b0;
      grp_same_next[g] = 1'b0;
      grp_idx_next[g]  = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (pad_same[g*GROUP+j] || pad_rev[g*GROUP+j]) begin
          grp_hit_next[g]  = 1'b1;
          grp_same_next[g] = pad_same[g*GROUP+j];
          grp_idx_next[g]  = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit[g]  <= grp_hit_next[g];
      grp_same[g] <= grp_same_next[g];
      grp_idx[g]  <= grp_idx_next[g];
    end
  end

  // lowest hit group wins
  always_comb begin
    sel_hit  = 1'b0;
    sel_same = 1'b0;
    sel_slot = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        sel_hit  = 1'b1;
        sel_same = grp_same[g];
        sel_slot = SLOT_W'(g * GROUP + int'(grp_idx[g]));
      end
    end
  end

  // ---------------------------------------------------------------- free stack
  // Stack depth equals free slots; entries below the low-water mark since the
  // last clear were never pushed and hold their initial slot number.
  assign f_count   = CNT_W'(MAX_FACES) - cnt;
  assign ram_raddr = SLOT_W'(f_count - 1'b1);
  assign pop_slot  = (f_count <= low_f) ? SLOT_W'(cnt) : ram_rdata;

  ofsc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_FACES)
  ) u_free_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- update
  always_comb begin
    cnt_next   = cnt;
    low_f_next = low_f;
    ram_we     = 1'b0;
    ram_waddr  = SLOT_W'(f_count);
    ram_wdata  = sel_slot;
    do_wr      = 1'b0;
    do_kill    = 1'b0;
    do_clr     = 1'b0;
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    if (upd_en) begin
      case (op)
        FUNC_CLEAR: begin
          do_clr     = 1'b1;
          cnt_next   = '0;
          low_f_next = CNT_W'(MAX_FACES);
          res_status = ST_CLEARED;
        end
        FUNC_INSERT: begin
          if (sel_hit && sel_same) begin
            res_status = ST_DUPLICATE;
            res_slot   = sel_slot;
          end else if (sel_hit) begin
            // cancel: free the slot and push it on the stack
            do_kill    = 1'b1;
            ram_we     = 1'b1;
            cnt_next   = cnt - 1'b1;
            res_status = ST_CANCELLED;
            res_slot   = sel_slot;
          end else if (cnt == CNT_W'(MAX_FACES)) begin
            res_status = ST_FULL;
          end else begin
            do_wr      = 1'b1;
            cnt_next   = cnt + 1'b1;
            if (f_count <= low_f) begin
              low_f_next = f_count - 1'b1;
            end
            res_status = ST_ADDED;
            res_slot   = pop_slot;
          end
        end
        default: begin
          if (sel_hit) begin
            res_status = sel_same ? ST_FOUND_SAME : ST_FOUND_REV;
            res_slot   = sel_slot;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      low_f <= CNT_W'(MAX_FACES);
      done  <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      low_f <= low_f_next;
      done  <= upd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      status     <= res_status;
      slot_index <= 6'(res_slot);
      face_count <= 7'(cnt_next);
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the oriented face set with cancellation.
`timescale 1ns / 1ps
module testbench;
  import ofsc_pkg::*;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;  // unused code, behaves as find
  localparam int         POOL_SIZE   = 100;
  localparam int         CYCLE_LIMIT = 200000;

  typedef logic [2:0][NODE_BITS-1:0] tri_t;

  typedef enum int {
    MATCH_NONE,
    MATCH_SAME,
    MATCH_REV
  } match_t;

  typedef struct {
    logic [2:0] status;
    logic [5:0] slot;
    logic [6:0] count;
  } face_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [23:0] face_node_a;
  logic [23:0] face_node_b;
  logic [23:0] face_node_c;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [6:0]  face_count;

  // Predicted table contents
  tri_t tbl_face  [MAX_FACES];
  bit   tbl_valid [MAX_FACES];
  int   tbl_next  [MAX_FACES];
  int   tbl_head;
  int   tbl_count;

  face_result_t expected_results[$];
  face_result_t want;
  tri_t         face_pool[POOL_SIZE];
  int           mismatches;
  int           cycle_count;
  bit           idle_on;

  oriented_face_set_cancel_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .face_node_a (face_node_a),
    .face_node_b (face_node_b),
    .face_node_c (face_node_c),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .face_count  (face_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void empty_table();
    for (int i = 0; i < MAX_FACES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_next[i]  = i + 1;
    end
    tbl_head  = 0;
    tbl_count = 0;
  endfunction

  // Lowest valid slot wins; same orientation is tested before reversed.
  function automatic match_t search_face(input tri_t n, output int slot);
    tri_t f;
    slot = 0;
    for (int i = 0; i < MAX_FACES; i++) begin
      if (tbl_valid[i]) begin
        f = tbl_face[i];
        if ((n[0] == f[0] && n[1] == f[1] && n[2] == f[2]) ||
            (n[1] == f[0] && n[2] == f[1] && n[0] == f[2]) ||
            (n[2] == f[0] && n[0] == f[1] && n[1] == f[2])) begin
          slot = i;
          return MATCH_SAME;
        end
        if ((n[2] == f[0] && n[1] == f[1] && n[0] == f[2]) ||
            (n[1] == f[0] && n[0] == f[1] && n[2] == f[2]) ||
            (n[0] == f[0] && n[2] == f[1] && n[1] == f[2])) begin
          slot = i;
          return MATCH_REV;
        end
      end
    end
    return MATCH_NONE;
  endfunction

  function automatic face_result_t apply_face_op(input logic [1:0] op, input tri_t n);
    face_result_t r;
    match_t       kind;
    int           slot;
    slot = 0;
    if (op == FUNC_CLEAR) begin
      empty_table();
      r.status = ST_CLEARED;
    end else if (op == FUNC_INSERT) begin
      kind = search_face(n, slot);
      if (kind == MATCH_SAME) begin
        r.status = ST_DUPLICATE;
      end else if (kind == MATCH_REV) begin
        tbl_valid[slot] = 1'b0;
        tbl_next[slot]  = tbl_head;
        tbl_head        = slot;
        if (tbl_count > 0) tbl_count--;
        r.status = ST_CANCELLED;
      end else if (tbl_head >= MAX_FACES) begin
        r.status = ST_FULL;
        slot     = 0;
      end else begin
        slot            = tbl_head;
        tbl_head        = tbl_next[slot];
        tbl_face[slot]  = n;
        tbl_valid[slot] = 1'b1;
        tbl_count++;
        r.status = ST_ADDED;
      end
    end else begin
      kind = search_face(n, slot);
      r.status = (kind == MATCH_SAME) ? ST_FOUND_SAME :
                 (kind == MATCH_REV)  ? ST_FOUND_REV  : ST_NOT_FOUND;
    end
    r.slot  = slot[5:0];
    r.count = tbl_count[6:0];
    return r;
  endfunction

  // Drive one command and record its expected result at the transfer edge.
  task automatic send_face_op(input logic [1:0] op, input logic [23:0] a,
                              input logic [23:0] b, input logic [23:0] c);
    int   gap;
    tri_t n;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       = 1'b1;
    func        = op;
    face_node_a = a;
    face_node_b = b;
    face_node_c = c;
    do @(posedge clk); while (busy);
    n[0] = a;
    n[1] = b;
    n[2] = c;
    expected_results.push_back(apply_face_op(op, n));
  endtask

  // Result checker: compare every strobed result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d slot_index %0d face_count %0d",
               status, slot_index, face_count);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatches++;
        end
        if (slot_index !== want.slot) begin
          $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
          mismatches++;
        end
        if (face_count !== want.count) begin
          $error("face_count: expected %0d, actual %0d", want.count, face_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    idle_on = 1'b1;
    send_face_op(FUNC_FIND,   24'd1, 24'd2, 24'd3);             // empty table
    send_face_op(FUNC_INSERT, 24'd0, 24'd0, 24'd0);
    send_face_op(FUNC_INSERT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_face_op(FUNC_INSERT, 24'd1, 24'd2, 24'd3);
    send_face_op(FUNC_INSERT, 24'd3, 24'd1, 24'd2);             // rotated duplicate
    send_face_op(FUNC_FIND,   24'd2, 24'd3, 24'd1);
    send_face_op(FUNC_FIND,   24'd3, 24'd2, 24'd1);
    send_face_op(FUNC_SPARE,  24'd1, 24'd3, 24'd2);
    send_face_op(FUNC_INSERT, 24'd5, 24'd5, 24'd7);             // repeated node
    send_face_op(FUNC_FIND,   24'd5, 24'd7, 24'd5);
    send_face_op(FUNC_INSERT, 24'd2, 24'd1, 24'd3);             // reversed: cancel
    send_face_op(FUNC_FIND,   24'd1, 24'd2, 24'd3);
    send_face_op(FUNC_INSERT, 24'hAAAAAA, 24'h555555, 24'h123456); // reuses freed slot
    send_face_op(FUNC_INSERT, 24'h555555, 24'hAAAAAA, 24'h123456);
    send_face_op(FUNC_INSERT, 24'd0, 24'd0, 24'd0);
    send_face_op(FUNC_SPARE,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_face_op(FUNC_CLEAR,  24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    send_face_op(FUNC_FIND,   24'd0, 24'd0, 24'd0);
    send_face_op(FUNC_INSERT, 24'd7, 24'd8, 24'd9);
    send_face_op(FUNC_CLEAR,  24'd0, 24'd0, 24'd0);
  endtask

  task automatic test_full_table();
    idle_on = 1'b0;
    for (int i = 0; i < MAX_FACES; i++)
      send_face_op(FUNC_INSERT, 24'(i), 24'(i + 1000), 24'(i + 2000));
    send_face_op(FUNC_INSERT, 24'd900, 24'd901, 24'd902);        // no free slot
    send_face_op(FUNC_INSERT, 24'd1010, 24'd2010, 24'd10);       // duplicate when full
    send_face_op(FUNC_FIND,   24'd63, 24'd1063, 24'd2063);
    send_face_op(FUNC_INSERT, 24'd2040, 24'd1040, 24'd40);       // cancel slot 40
    send_face_op(FUNC_INSERT, 24'd5, 24'd2005, 24'd1005);        // cancel slot 5
    send_face_op(FUNC_INSERT, 24'd900, 24'd901, 24'd902);
    send_face_op(FUNC_INSERT, 24'd903, 24'd904, 24'd905);
    send_face_op(FUNC_INSERT, 24'd906, 24'd907, 24'd908);
    send_face_op(FUNC_CLEAR,  24'd0, 24'd0, 24'd0);
  endtask

  function automatic void fill_pool();
    for (int i = 0; i < POOL_SIZE; i++)
      for (int k = 0; k < 3; k++)
        face_pool[i][k] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 15))
                                                     : 24'($urandom());
  endfunction

  // Mostly faces from a shared pool in random orientation, so that inserts,
  // cancels, duplicates and a full table all happen; the rest is noise.
  task automatic test_random_ops(input int n_items, input bit with_idle);
    tri_t       f;
    int         r;
    int         roll;
    logic [1:0] op;
    fill_pool();
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) idle_on = with_idle && ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 199);
      if (roll == 0) begin
        send_face_op(FUNC_CLEAR, 24'($urandom()), 24'($urandom()), 24'($urandom()));
      end else if (roll <= 20) begin
        case ($urandom_range(0, 2))
          0:       op = FUNC_INSERT;
          1:       op = FUNC_FIND;
          default: op = FUNC_SPARE;
        endcase
        send_face_op(op, 24'($urandom()), 24'($urandom()), 24'($urandom()));
      end else begin
        f = face_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 2);
        if ($urandom_range(0, 9) < 6) op = FUNC_INSERT;
        else op = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : FUNC_FIND;
        if ($urandom_range(0, 1) == 0)
          send_face_op(op, f[r], f[(r + 1) % 3], f[(r + 2) % 3]);
        else
          send_face_op(op, f[r], f[(r + 2) % 3], f[(r + 1) % 3]);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = FUNC_INSERT;
    face_node_a = '0;
    face_node_b = '0;
    face_node_c = '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_on     = 1'b0;
    empty_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_table();
    test_random_ops(900, 1'b1);
    test_random_ops(150, 1'b0);

    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ofsc_pkg.sv
hdl/ofsc_ram.sv
hdl/ofsc_cell.sv
hdl/oriented_face_set_cancel_top.sv
tb/testbench.sv
